FILE: rtl/core/lpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpu_pkg;

   localparam int HDR_LEN = 20;

   localparam logic [3:0] IP_VERSION = 4'd4;
   localparam logic [3:0] IP_IHL     = 4'd5;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_PREFIX  = 3'd1,
      PH_PREFIX2 = 3'd2,
      PH_FIRST   = 3'd3,
      PH_DROP    = 3'd4,
      PH_DATA    = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_VERSION   = 3'd2,
      ST_OPTIONS   = 3'd3,
      ST_CHECKSUM  = 3'd4,
      ST_FILTERED  = 3'd5,
      ST_OVERSIZE  = 3'd6,
      ST_TRUNCATED = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_EMPTY  = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       sub_first;
      logic       sub_last;
      logic [7:0] sub_number;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type item;
   } rsp_slot_type;

endpackage

`default_nettype wire

FILE: rtl/core/lpu_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lpu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_datagram;

   modport source (output valid, output in_byte, output end_of_datagram, input ready);
   modport sink   (input valid, input in_byte, input end_of_datagram, output ready);
endinterface

interface lpu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       sub_first;
   logic       sub_last;
   logic [7:0] sub_number;
   logic [2:0] status;

   modport source (output valid, output kind, output data_byte, output sub_first,
                   output sub_last, output sub_number, output status, input ready);
   modport sink   (input valid, input kind, input data_byte, input sub_first,
                   input sub_last, input sub_number, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lpu_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module lpu_parser import lpu_pkg::*; #(
   parameter int MAX_SUB_LEN  = 5120,
   parameter int MAX_DATAGRAM = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          take,
   input  wire logic [7:0]    in_byte,
   input  wire logic          end_of_datagram,
   input  wire logic [31:0]   dest_filter,
   output rsp_slot_type       slot_sub,
   output rsp_slot_type       slot_end
);

   localparam int PW = $clog2(MAX_DATAGRAM + 1);
   localparam int BW = $clog2(MAX_SUB_LEN + 1);
   localparam logic [PW-1:0] POS_MAX  = PW'(MAX_DATAGRAM);
   localparam logic [PW-1:0] HDR_LAST = PW'(HDR_LEN - 1);
   localparam logic [PW-1:0] HDR_END  = PW'(HDR_LEN);
   localparam logic [14:0]   LEN_MAX  = 15'(MAX_SUB_LEN);

   logic [PW-1:0] pos_ff, pos_in, pos_step;
   phase_type     phase_ff, phase_in, phase_step;
   logic [15:0]   sum_ff, sum_in, sum_step;
   logic [31:0]   dest_ff, dest_in, dest_step;
   logic [6:0]    first_ff, first_in, first_step;
   logic [BW-1:0] left_ff, left_in, left_step;
   logic [7:0]    cnt_ff, cnt_in, cnt_step;
   status_type    lat_ff, lat_in, lat_step;

   logic          work;
   logic          start_sub;
   logic          is_data;
   logic [14:0]   len_cand;
   logic          len_over;
   logic          len_zero;
   logic [BW-1:0] left_dec;
   logic          data_last;
   logic [7:0]    cnt_inc;
   logic [16:0]   sum_wide;
   logic [15:0]   sum_fold;
   logic [31:0]   dest_shift;
   status_type    lat_hdr;
   logic          close;
   status_type    end_status;

   assign work      = take && (pos_ff < POS_MAX);
   assign len_cand  = (phase_ff == PH_PREFIX2) ? {first_ff, in_byte} : {8'd0, in_byte[6:0]};
   assign start_sub = work && ((phase_ff == PH_PREFIX && !in_byte[7]) ||
                               phase_ff == PH_PREFIX2);
   assign len_over  = len_cand > LEN_MAX;
   assign len_zero  = len_cand == 15'd0;
   assign is_data   = work && (phase_ff == PH_FIRST || phase_ff == PH_DATA);
   assign left_dec  = left_ff - BW'(1);
   assign data_last = left_dec == '0;
   assign cnt_inc   = (cnt_ff != 8'hFF) ? cnt_ff + 8'd1 : cnt_ff;

   // ones-complement sum with end-around carry
   assign sum_wide   = {1'b0, sum_ff} + (pos_ff[0] ? {9'd0, in_byte} : {1'b0, in_byte, 8'd0});
   assign sum_fold   = sum_wide[15:0] + {15'd0, sum_wide[16]};
   assign dest_shift = {dest_ff[23:0], in_byte};

   always_comb begin
      lat_hdr = lat_ff;
      if (pos_ff == '0) begin
         if (in_byte[7:4] != IP_VERSION) begin
            lat_hdr = ST_VERSION;
         end else if (in_byte[3:0] != IP_IHL) begin
            lat_hdr = ST_OPTIONS;
         end else begin
            lat_hdr = ST_OK;
         end
      end
   end

   // per-byte state step
   always_comb begin
      pos_step   = work ? pos_ff + PW'(1) : pos_ff;
      phase_step = phase_ff;
      sum_step   = sum_ff;
      dest_step  = dest_ff;
      first_step = first_ff;
      left_step  = left_ff;
      cnt_step   = cnt_ff;
      lat_step   = lat_ff;
      if (work) begin
         case (phase_ff)
            PH_HEADER: begin
               sum_step  = sum_fold;
               dest_step = dest_shift;
               lat_step  = lat_hdr;
               if (pos_ff == HDR_LAST) begin
                  if (lat_hdr == ST_OK) begin
                     if (sum_fold != 16'hFFFF) begin
                        lat_step = ST_CHECKSUM;
                     end else if (dest_filter != 32'd0 && dest_shift != dest_filter) begin
                        lat_step = ST_FILTERED;
                     end
                  end
                  phase_step = (lat_step != ST_OK) ? PH_DROP : PH_PREFIX;
               end
            end
            PH_PREFIX, PH_PREFIX2: begin
               if (phase_ff == PH_PREFIX && in_byte[7]) begin
                  first_step = in_byte[6:0];
                  phase_step = PH_PREFIX2;
               end else if (len_over) begin
                  lat_step   = ST_OVERSIZE;
                  phase_step = PH_DROP;
               end else if (len_zero) begin
                  cnt_step   = cnt_inc;
                  phase_step = PH_PREFIX;
               end else begin
                  left_step  = BW'(len_cand);
                  phase_step = PH_FIRST;
               end
            end
            PH_FIRST, PH_DATA: begin
               left_step = left_dec;
               if (data_last) begin
                  cnt_step   = cnt_inc;
                  phase_step = PH_PREFIX;
               end else begin
                  phase_step = PH_DATA;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign close = take && end_of_datagram;

   always_comb begin
      if (pos_step <= HDR_END) begin
         end_status = ST_SHORT;
      end else if (lat_step != ST_OK) begin
         end_status = lat_step;
      end else if (phase_step == PH_PREFIX2 || phase_step == PH_FIRST ||
                   phase_step == PH_DATA) begin
         end_status = ST_TRUNCATED;
      end else begin
         end_status = ST_OK;
      end
   end

   // clear the datagram state once its status item is out
   always_comb begin
      if (close) begin
         pos_in   = '0;
         phase_in = PH_HEADER;
         sum_in   = '0;
         dest_in  = '0;
         first_in = '0;
         left_in  = '0;
         cnt_in   = '0;
         lat_in   = ST_OK;
      end else begin
         pos_in   = pos_step;
         phase_in = phase_step;
         sum_in   = sum_step;
         dest_in  = dest_step;
         first_in = first_step;
         left_in  = left_step;
         cnt_in   = cnt_step;
         lat_in   = lat_step;
      end
   end

   // result items
   always_comb begin
      slot_sub.valid           = 1'b0;
      slot_sub.item.kind       = KIND_BYTE;
      slot_sub.item.data_byte  = 8'd0;
      slot_sub.item.sub_first  = 1'b0;
      slot_sub.item.sub_last   = 1'b0;
      slot_sub.item.sub_number = cnt_ff;
      slot_sub.item.status     = ST_OK;
      if (is_data) begin
         slot_sub.valid          = 1'b1;
         slot_sub.item.data_byte = in_byte;
         slot_sub.item.sub_first = phase_ff == PH_FIRST;
         slot_sub.item.sub_last  = data_last;
      end else if (start_sub && !len_over && len_zero) begin
         slot_sub.valid          = 1'b1;
         slot_sub.item.kind      = KIND_EMPTY;
         slot_sub.item.sub_first = 1'b1;
         slot_sub.item.sub_last  = 1'b1;
      end

      slot_end.valid           = close;
      slot_end.item.kind       = KIND_STATUS;
      slot_end.item.data_byte  = 8'd0;
      slot_end.item.sub_first  = 1'b0;
      slot_end.item.sub_last   = 1'b0;
      slot_end.item.sub_number = cnt_step;
      slot_end.item.status     = end_status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= PH_HEADER;
         sum_ff   <= '0;
         dest_ff  <= '0;
         first_ff <= '0;
         left_ff  <= '0;
         cnt_ff   <= '0;
         lat_ff   <= ST_OK;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         dest_ff  <= dest_in;
         first_ff <= first_in;
         left_ff  <= left_in;
         cnt_ff   <= cnt_in;
         lat_ff   <= lat_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ipv4_length_prefix_unpacker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake          Carries
// req_chan  in    valid/ready        in_byte, end_of_datagram
// rsp_chan  out   valid/ready        kind, data_byte, sub_first, sub_last, sub_number, status
// csr_*     in    csr_wr_en strobe   dest_filter
//
// One byte is taken per cycle while req_chan.ready is high; its results land in a
// four-entry output queue on the same edge and can leave on the next one. A byte yields
// at most two items (a sub-packet item and the status item); the queue drains one item a
// cycle while rsp_chan.ready is high, so req_chan.ready drops only when fewer than two
// entries are free. Reset clears the parser and the queue; dest_filter returns to zero.

module ipv4_length_prefix_unpacker_unit import lpu_pkg::*; #(
   parameter int MAX_SUB_LEN  = 5120,
   parameter int MAX_DATAGRAM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   lpu_req_if.sink          req_chan,
   lpu_rsp_if.source        rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   logic [31:0]   filter_ff, filter_in;
   rsp_type       queue_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   rsp_slot_type  slot_sub;
   rsp_slot_type  slot_end;
   logic          take;
   logic          pop;
   logic [AW-1:0] end_ptr;
   logic [AW:0]   pushes;
   rsp_type       head;

   assign req_chan.ready = count_ff <= (AW+1)'(DEPTH - 2);
   assign take           = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;

   lpu_parser #(
      .MAX_SUB_LEN  (MAX_SUB_LEN),
      .MAX_DATAGRAM (MAX_DATAGRAM)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .in_byte         (req_chan.in_byte),
      .end_of_datagram (req_chan.end_of_datagram),
      .dest_filter     (filter_ff),
      .slot_sub        (slot_sub),
      .slot_end        (slot_end)
   );

   assign filter_in = csr_wr_en ? csr_wr_data : filter_ff;

   // status item follows the sub-packet item when both occur
   assign end_ptr   = wr_ptr_ff + AW'(slot_sub.valid);
   assign pushes    = (AW+1)'(slot_sub.valid) + (AW+1)'(slot_end.valid);
   assign wr_ptr_in = wr_ptr_ff + pushes[AW-1:0];
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + pushes - (AW+1)'(pop);

   assign head                = queue_ff[rd_ptr_ff];
   assign rsp_chan.valid      = count_ff != '0;
   assign rsp_chan.kind       = head.kind;
   assign rsp_chan.data_byte  = head.data_byte;
   assign rsp_chan.sub_first  = head.sub_first;
   assign rsp_chan.sub_last   = head.sub_last;
   assign rsp_chan.sub_number = head.sub_number;
   assign rsp_chan.status     = head.status;

   always_ff @(posedge clock) begin
      if (slot_sub.valid) begin
         queue_ff[wr_ptr_ff] <= slot_sub.item;
      end
      if (slot_end.valid) begin
         queue_ff[end_ptr] <= slot_end.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         filter_ff <= filter_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: tb/ipv4_length_prefix_unpacker_unit_test.sv
`timescale 1ns / 1ps

module ipv4_length_prefix_unpacker_unit_test;
   import lpu_pkg::*;

   localparam int MAX_SUB_LEN  = 5120;
   localparam int MAX_DATAGRAM = 4096;
   localparam int RANDOM_BYTES = 600;
   localparam int SETTLE       = 8;
   localparam int LONG_HOLD    = 60;

   typedef enum {ROW_FRAME, ROW_FILTER} row_op_type;
   typedef enum {HDR_GOOD, HDR_VERSION, HDR_OPTIONS, HDR_CHECKSUM, HDR_NOISE} header_case_type;

   // len_a/len_b of -1 leave that sub-packet out; wide forces two-byte prefixes.
   typedef struct {
      row_op_type      op;
      header_case_type hdr;
      logic [31:0]     addr;
      int              len_a;
      int              len_b;
      bit              wide;
      int              empties;
      int              cut;
      int              tail;
      bit              typed;
      status_type      st;
      int              num;
   } frame_row_type;

   frame_row_type plan [0:22] = '{
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0001,    -1,   -1, 0,   1,   0, 0, 1, ST_OK,        1},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0002,    -1,   -1, 0,   0,   0, 0, 1, ST_SHORT,     0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0003,    -1,   -1, 0,   0,  19, 0, 1, ST_SHORT,     0},
      '{ROW_FRAME,  HDR_VERSION,  32'h0A00_0004,     3,   -1, 0,   0,   0, 0, 1, ST_VERSION,   0},
      '{ROW_FRAME,  HDR_OPTIONS,  32'h0A00_0005,     2,   -1, 0,   0,   0, 0, 1, ST_OPTIONS,   0},
      '{ROW_FRAME,  HDR_CHECKSUM, 32'h0A00_0006,     1,   -1, 0,   0,   0, 0, 1, ST_CHECKSUM,  0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0007,     1,  127, 0,   0,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0008,   128,    5, 1,   0,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0009,     2, 5121, 1,   0,   0, 0, 1, ST_OVERSIZE,  1},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_000A, 32767,   -1, 1,   0,   0, 0, 1, ST_OVERSIZE,  0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_000B,     6,   -1, 0,   0,   2, 0, 1, ST_TRUNCATED, 0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_000C,     3,  200, 0,   0, 201, 0, 1, ST_TRUNCATED, 1},
      '{ROW_FILTER, HDR_GOOD,     32'hC0A8_0001,    -1,   -1, 0,   0,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'hC0A8_0001,     4,   -1, 0,   0,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'hC0A8_0002,     4,   -1, 0,   0,   0, 0, 1, ST_FILTERED,  0},
      '{ROW_FILTER, HDR_GOOD,     32'hFFFF_FFFF,    -1,   -1, 0,   0,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'hFFFF_FFFF,    -1,   -1, 0,   2,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0000_0000,     4,   -1, 0,   0,   0, 0, 1, ST_FILTERED,  0},
      '{ROW_FILTER, HDR_GOOD,     32'h0000_0000,    -1,   -1, 0,   0,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0014,  4074,   -1, 1,   0,   0, 5, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0015,  5120,   -1, 1,   0,   0, 0, 1, ST_TRUNCATED, 0},
      '{ROW_FRAME,  HDR_GOOD,     32'h0A00_0016,    -1,   -1, 0, 300,   0, 0, 0, ST_OK,        0},
      '{ROW_FRAME,  HDR_NOISE,    32'h0A00_0017,     4,   -1, 0,   0,   0, 0, 0, ST_OK,        0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   lpu_req_if req_bus ();
   lpu_rsp_if rsp_bus ();

   ipv4_length_prefix_unpacker_unit #(
      .MAX_SUB_LEN  (MAX_SUB_LEN),
      .MAX_DATAGRAM (MAX_DATAGRAM)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state of the predictor
   logic [31:0] dest_filter_copy;
   int          rx_pos;
   phase_type   rx_phase;
   logic [15:0] rx_sum;
   logic [31:0] rx_dest;
   logic [6:0]  rx_len_hi;
   logic [15:0] rx_left;
   logic [7:0]  rx_count;
   status_type  rx_status;

   rsp_type    due_items [$];
   logic [7:0] frame_bytes [$];
   int         mismatch_count = 0;
   bit         src_idle  = 1'b1;
   bit         sink_idle = 1'b1;
   bit         hold_req  = 1'b0;

   function automatic void reset_parse();
      rx_pos    = 0;
      rx_phase  = PH_HEADER;
      rx_sum    = '0;
      rx_dest   = '0;
      rx_len_hi = '0;
      rx_left   = '0;
      rx_count  = '0;
      rx_status = ST_OK;
   endfunction

   function automatic void emit(input kind_type k, input logic [7:0] d, input logic first,
                                input logic last, input logic [7:0] num, input status_type st);
      rsp_type r;
      r.kind       = k;
      r.data_byte  = d;
      r.sub_first  = first;
      r.sub_last   = last;
      r.sub_number = num;
      r.status     = st;
      due_items.push_back(r);
   endfunction

   function automatic void count_sub();
      if (rx_count != 8'hFF) begin
         rx_count++;
      end
   endfunction

   function automatic void open_sub(input int len);
      if (len > MAX_SUB_LEN) begin
         rx_status = ST_OVERSIZE;
         rx_phase  = PH_DROP;
      end else if (len == 0) begin
         emit(KIND_EMPTY, 8'd0, 1'b1, 1'b1, rx_count, ST_OK);
         count_sub();
         rx_phase = PH_PREFIX;
      end else begin
         rx_left  = 16'(len);
         rx_phase = PH_FIRST;
      end
   endfunction

   function automatic void unpack_byte(input logic [7:0] b, input logic eod);
      int          idx;
      logic [16:0] wide_sum;
      status_type  st;
      if (rx_pos < MAX_DATAGRAM) begin
         idx = rx_pos;
         rx_pos++;
         case (rx_phase)
            PH_HEADER: begin
               if (idx == 0) begin
                  if (b[7:4] != IP_VERSION) begin
                     rx_status = ST_VERSION;
                  end else if (b[3:0] != IP_IHL) begin
                     rx_status = ST_OPTIONS;
                  end else begin
                     rx_status = ST_OK;
                  end
               end
               // even offsets carry the high byte of each 16-bit word
               wide_sum = {1'b0, rx_sum} + (idx[0] ? {9'd0, b} : {1'b0, b, 8'd0});
               rx_sum   = wide_sum[15:0] + 16'(wide_sum[16]);
               rx_dest  = {rx_dest[23:0], b};
               if (idx == HDR_LEN - 1) begin
                  if (rx_status == ST_OK) begin
                     if (rx_sum != 16'hFFFF) begin
                        rx_status = ST_CHECKSUM;
                     end else if (dest_filter_copy != 0 && rx_dest != dest_filter_copy) begin
                        rx_status = ST_FILTERED;
                     end
                  end
                  rx_phase = (rx_status != ST_OK) ? PH_DROP : PH_PREFIX;
               end
            end
            PH_PREFIX: begin
               if (b[7]) begin
                  rx_len_hi = b[6:0];
                  rx_phase  = PH_PREFIX2;
               end else begin
                  open_sub(int'(b));
               end
            end
            PH_PREFIX2: open_sub(int'({rx_len_hi, b}));
            PH_FIRST, PH_DATA: begin
               rx_left = rx_left - 16'd1;
               emit(KIND_BYTE, b, rx_phase == PH_FIRST, rx_left == 0, rx_count, ST_OK);
               if (rx_left == 0) begin
                  count_sub();
                  rx_phase = PH_PREFIX;
               end else begin
                  rx_phase = PH_DATA;
               end
            end
            default: ;
         endcase
      end
      if (eod) begin
         if (rx_pos <= HDR_LEN) begin
            st = ST_SHORT;
         end else if (rx_status != ST_OK) begin
            st = rx_status;
         end else if (rx_phase == PH_PREFIX2 || rx_phase == PH_FIRST || rx_phase == PH_DATA) begin
            st = ST_TRUNCATED;
         end else begin
            st = ST_OK;
         end
         emit(KIND_STATUS, 8'd0, 1'b0, 1'b0, rx_count, st);
         reset_parse();
      end
   endfunction

   // Build a 20-byte header with a correct checksum, then break it as asked.
   function automatic void make_header(input header_case_type hc, input logic [31:0] dest);
      logic [7:0]  h [20];
      logic [31:0] acc;
      logic [15:0] csum;
      for (int i = 0; i < 20; i++) begin
         h[i] = 8'($urandom);
      end
      h[0]  = {IP_VERSION, IP_IHL};
      h[10] = 8'd0;
      h[11] = 8'd0;
      {h[16], h[17], h[18], h[19]} = dest;
      if (hc == HDR_VERSION) begin
         h[0][7:4] = IP_VERSION ^ 4'($urandom_range(1, 15));
      end else if (hc == HDR_OPTIONS) begin
         h[0][3:0] = IP_IHL ^ 4'($urandom_range(1, 15));
      end
      acc = '0;
      for (int i = 0; i < 10; i++) begin
         acc += {16'd0, h[2 * i], h[2 * i + 1]};
      end
      acc   = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      acc   = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
      csum  = ~acc[15:0];
      h[10] = csum[15:8];
      h[11] = csum[7:0];
      if (hc == HDR_CHECKSUM) begin
         h[11] ^= 8'($urandom_range(1, 255));
      end else if (hc == HDR_NOISE) begin
         for (int i = 0; i < 20; i++) begin
            h[i] = 8'($urandom);
         end
      end
      for (int i = 0; i < 20; i++) begin
         frame_bytes.push_back(h[i]);
      end
   endfunction

   function automatic void push_sub(input int len, input bit wide);
      int n;
      if (wide || len >= 128) begin
         frame_bytes.push_back({1'b1, 7'(len >> 8)});
         frame_bytes.push_back(8'(len));
      end else begin
         frame_bytes.push_back(8'(len));
      end
      n = (len > MAX_SUB_LEN) ? $urandom_range(0, 5) : len;
      repeat (n) frame_bytes.push_back(8'($urandom));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eod);
      if (src_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.in_byte         <= b;
      req_bus.end_of_datagram <= eod;
      do @(posedge clock); while (!req_bus.ready);
      unpack_byte(b, eod);
   endtask

   task automatic send_frame(input bit typed, input status_type st, input int num);
      rsp_type fixed;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      // the status item is typed in for rows where it is obvious
      if (typed) begin
         fixed            = due_items.pop_back();
         fixed.status     = st;
         fixed.sub_number = 8'(num);
         due_items.push_back(fixed);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (due_items.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_filter(input logic [31:0] value);
      drain();
      csr_wr_en        <= 1'b1;
      csr_wr_data      <= value;
      dest_filter_copy = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : sink_driver
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            // hold off long enough for the output queue to fill and stall input
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_type'({rsp_bus.kind, rsp_bus.data_byte, rsp_bus.sub_first, rsp_bus.sub_last,
                          rsp_bus.sub_number, rsp_bus.status});
         if (due_items.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected item at %0t: kind=%0d data=%02h first=%0b last=%0b num=%0d st=%0d",
                        $realtime, got.kind, got.data_byte, got.sub_first, got.sub_last,
                        got.sub_number, got.status);
            end
         end else begin
            want = due_items.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch at %0t: expected kind=%0d data=%02h first=%0b last=%0b num=%0d st=%0d",
                           $realtime, want.kind, want.data_byte, want.sub_first, want.sub_last,
                           want.sub_number, want.status);
                  $display("                  actual kind=%0d data=%02h first=%0b last=%0b num=%0d st=%0d",
                           got.kind, got.data_byte, got.sub_first, got.sub_last,
                           got.sub_number, got.status);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #20_000_000;
      $display("ipv4_length_prefix_unpacker_unit_test failed");
      $finish;
   end

   initial begin : stimulus
      int              normal_bytes;
      int              dgram;
      int              len;
      int              pick;
      bit              short_frame;
      logic [31:0]     dest;
      header_case_type hc;
      req_bus.valid           <= 1'b0;
      req_bus.in_byte         <= 8'd0;
      req_bus.end_of_datagram <= 1'b0;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= 32'd0;
      dest_filter_copy = 32'd0;
      reset_parse();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         if (plan[r].op == ROW_FILTER) begin
            set_filter(plan[r].addr);
         end else begin
            frame_bytes.delete();
            make_header(plan[r].hdr, plan[r].addr);
            if (plan[r].len_a >= 0) push_sub(plan[r].len_a, plan[r].wide);
            if (plan[r].len_b >= 0) push_sub(plan[r].len_b, plan[r].wide);
            repeat (plan[r].empties) frame_bytes.push_back(8'd0);
            repeat (plan[r].tail) frame_bytes.push_back(8'($urandom));
            repeat (plan[r].cut) void'(frame_bytes.pop_back());
            send_frame(plan[r].typed, plan[r].st, plan[r].num);
         end
      end

      normal_bytes = 0;
      dgram        = 0;
      while (normal_bytes < RANDOM_BYTES) begin
         if (dgram % 6 == 5) begin
            pick = $urandom_range(0, 3);
            set_filter(pick == 0 ? 32'd0 : pick == 1 ? 32'hFFFF_FFFF : 32'($urandom));
         end
         if (normal_bytes < RANDOM_BYTES - 150) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
         end else begin
            src_idle  = 1'b0;
            sink_idle = 1'b0;
         end
         if (dgram == 3) hold_req = 1'b1;
         if (dgram == 8) drain();

         frame_bytes.delete();
         dest = (dest_filter_copy != 0 && $urandom_range(0, 5) != 0) ?
                dest_filter_copy : 32'($urandom);
         pick        = $urandom_range(0, 99);
         short_frame = pick >= 95;
         hc = pick < 75 ? HDR_GOOD : pick < 80 ? HDR_VERSION : pick < 85 ? HDR_OPTIONS :
              pick < 90 ? HDR_CHECKSUM : pick < 95 ? HDR_NOISE : HDR_GOOD;
         make_header(hc, dest);
         if (dgram == 4) begin
            push_sub($urandom_range(4070, 4200), 1'b1);
         end else if (dgram == 7) begin
            // push the sub-packet index past saturation
            repeat ($urandom_range(256, 300)) frame_bytes.push_back(8'd0);
            push_sub(3, 1'b0);
         end else begin
            repeat ($urandom_range(0, 4)) begin
               pick = $urandom_range(0, 19);
               len  = pick < 12 ? $urandom_range(0, 8) : pick < 15 ? $urandom_range(120, 140) :
                      pick < 18 ? $urandom_range(0, 300) : pick == 18 ?
                      $urandom_range(MAX_SUB_LEN + 1, 32767) : $urandom_range(141, 600);
               push_sub(len, len < 128 && $urandom_range(0, 4) == 0);
            end
         end
         if (short_frame) begin
            len = $urandom_range(1, 20);
            while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 2 && frame_bytes.size() > 23) begin
               repeat ($urandom_range(1, 3)) void'(frame_bytes.pop_back());
            end else if (pick == 2) begin
               repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
            end
         end
         if (dgram != 4 && dgram != 7) normal_bytes += frame_bytes.size();
         send_frame(1'b0, ST_OK, 0);
         dgram++;
      end

      drain();
      if (mismatch_count == 0 && due_items.size() == 0) begin
         $display("ipv4_length_prefix_unpacker_unit_test passed");
      end else begin
         $display("ipv4_length_prefix_unpacker_unit_test failed");
      end
      $finish;
   end

endmodule
